// ----- sv/htbc_pkg.sv -----
// Shared types, band threshold and colour tables for the temperature band classifier.
// No dependencies.
package htbc_pkg;

   localparam int TEMP_W             = 15;
   localparam int DEADBAND_W         = 10;
   localparam int BAND_OUT_W         = 3;
   localparam int TABLE_LEN          = 7;
   localparam int TABLE_IDX_W        = $clog2(TABLE_LEN);
   localparam int BAND_COUNT_DEFAULT = 7;
   localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 10'd10;

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic signed [15:0]       thr_type;

   localparam temp_type SENTINEL = -15'sd12700;

   localparam thr_type HEAT_TH [TABLE_LEN] = '{
      16'sd0, 16'sd3500, 16'sd6200, 16'sd7100, 16'sd7700, 16'sd8200, 16'sd8600
   };
   localparam thr_type COOL_TH [TABLE_LEN] = '{
      -16'sd5000, 16'sd2500, 16'sd5500, 16'sd6800, 16'sd7400, 16'sd7900, 16'sd8400
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   localparam rgb_type BAND_RGB [TABLE_LEN] = '{
      '{8'd255, 8'd0,   8'd255},
      '{8'd0,   8'd0,   8'd255},
      '{8'd100, 8'd200, 8'd255},
      '{8'd0,   8'd255, 8'd255},
      '{8'd0,   8'd255, 8'd0},
      '{8'd255, 8'd210, 8'd0},
      '{8'd255, 8'd0,   8'd0}
   };

   typedef struct packed {
      logic                  rising;
      logic [7:0]            blue;
      logic [7:0]            green;
      logic [7:0]            red;
      logic [BAND_OUT_W-1:0] band;
      logic                  color_change;
      logic                  accepted;
   } result_type;

   // Indices past the table take the last entry.
   function automatic rgb_type band_color(input int unsigned idx);
      rgb_type c;
      if (idx >= TABLE_LEN) begin
         c = BAND_RGB[TABLE_LEN-1];
      end else begin
         c = BAND_RGB[TABLE_IDX_W'(idx)];
      end
      return c;
   endfunction

endpackage

// ----- sv/hysteresis_temperature_band_classifier_unit.sv -----
// Temperature band classifier with hysteresis: input register, decision logic, result register.
// Input register then result register between req transaction and rsp_tvalid; one transaction per cycle
// sustained while rsp_tready allows, as htbc_core updates its state on each step. Reset is synchronous: deadband 10,
// no stored reading, direction heating, band 0. Depends on htbc_pkg and htbc_core.
module hysteresis_temperature_band_classifier_unit #(
   parameter int BAND_COUNT = htbc_pkg::BAND_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,  // temp_centi[14:0], fade_busy[15]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // accepted[0], color_change[1], band[4:2], red[12:5], green[20:13], blue[28:21],
   // rising[29], zero[31:30]
   output logic [31:0]                         rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [htbc_pkg::DEADBAND_W-1:0]     csr_data
);
   import htbc_pkg::*;

   logic                   in_valid_ff;
   temp_type               in_temp_ff;
   logic                   in_busy_ff;
   logic                   out_valid_ff;
   result_type             out_ff;
   logic [DEADBAND_W-1:0]  deadband_ff;
   logic                   advance;
   logic                   step;
   result_type             result;

   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

   htbc_core #(
      .BAND_COUNT (BAND_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .temp      (in_temp_ff),
      .fade_busy (in_busy_ff),
      .deadband  (deadband_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         deadband_ff  <= DEADBAND_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_valid) begin
            deadband_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_temp_ff <= temp_type'(req_tdata[14:0]);
         in_busy_ff <= req_tdata[15];
      end
      if (step) begin
         out_ff <= result;
      end
   end

endmodule

// ----- sv/htbc_band.sv -----
// Band index mover: parallel compares against heat and cool thresholds.
// Depends on htbc_pkg.
module htbc_band #(
   parameter int BAND_COUNT = htbc_pkg::BAND_COUNT_DEFAULT
) (
   input  htbc_pkg::temp_type             temp,
   input  logic [$clog2(BAND_COUNT)-1:0]  cur_band,
   input  logic                           rising,
   output logic [$clog2(BAND_COUNT)-1:0]  new_band
);
   import htbc_pkg::*;

   localparam int BandW  = $clog2(BAND_COUNT);
   localparam int TopIdx = (BAND_COUNT - 1 < TABLE_LEN - 1) ? BAND_COUNT - 1 : TABLE_LEN - 1;
   localparam logic [BandW-1:0] TopBand = BandW'(BAND_COUNT - 1);

   thr_type                 temp_ext;
   logic [BAND_COUNT-1:1]   heat_ok;
   logic [BAND_COUNT-1:1]   cool_above;
   logic [BandW-1:0]        heat_cnt;
   logic [BandW-1:0]        cool_cnt;
   logic [BandW-1:0]        cur;

   assign temp_ext = thr_type'(temp);

   // Thresholds rise with the index, so each compare row is a thermometer code.
   for (genvar i = 1; i < BAND_COUNT; i++) begin : g_cmp
      localparam int Ti = (i < TABLE_LEN) ? i : TABLE_LEN - 1;
      assign heat_ok[i]    = temp_ext >= HEAT_TH[Ti];
      assign cool_above[i] = temp_ext >  COOL_TH[Ti];
   end

   always_comb begin
      heat_cnt = '0;
      cool_cnt = '0;
      for (int i = 1; i < BAND_COUNT; i++) begin
         heat_cnt = heat_cnt + BandW'(heat_ok[i]);
         cool_cnt = cool_cnt + BandW'(cool_above[i]);
      end
      cur = (cur_band > TopBand) ? TopBand : cur_band;
      if (temp_ext < 16'sd0) begin
         new_band = '0;
      end else if (temp_ext >= HEAT_TH[TopIdx]) begin
         new_band = TopBand;
      end else if (rising) begin
         new_band = (heat_cnt > cur) ? heat_cnt : cur;
      end else begin
         new_band = (cool_cnt < cur) ? cool_cnt : cur;
      end
   end

endmodule

// ----- sv/htbc_core.sv -----
// Classifier state and per-reading decision: gating, deadband, band move, colour change.
// Depends on htbc_pkg and htbc_band.
module htbc_core #(
   parameter int BAND_COUNT = htbc_pkg::BAND_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  htbc_pkg::temp_type                  temp,
   input  logic                                fade_busy,
   input  logic [htbc_pkg::DEADBAND_W-1:0]     deadband,
   output htbc_pkg::result_type                result
);
   import htbc_pkg::*;

   localparam int BandW = $clog2(BAND_COUNT);

   temp_type          last_temp_ff, last_temp_in;
   logic              have_last_ff, have_last_in;
   logic              rising_ff, rising_in;
   logic [BandW-1:0]  band_ff, band_in;
   logic [BandW-1:0]  disp_ff, disp_in;

   thr_type           diff;
   logic [15:0]       abs_diff;
   logic              valid_reading;
   logic              accept;
   logic              rising_use;
   logic              chg;
   logic [BandW-1:0]  moved_band;
   rgb_type           new_rgb;
   rgb_type           disp_rgb;
   rgb_type           cur_rgb;

   htbc_band #(
      .BAND_COUNT (BAND_COUNT)
   ) u_band (
      .temp     (temp),
      .cur_band (band_ff),
      .rising   (rising_use),
      .new_band (moved_band)
   );

   always_comb begin
      diff          = thr_type'(temp) - thr_type'(last_temp_ff);
      abs_diff      = diff[15] ? 16'(-diff) : 16'(diff);
      valid_reading = !fade_busy && (temp != SENTINEL);
      accept        = valid_reading && (!have_last_ff || (abs_diff > 16'(deadband)));
      rising_use    = have_last_ff ? (temp > last_temp_ff) : rising_ff;
      new_rgb       = band_color(int'(moved_band));
      disp_rgb      = band_color(int'(disp_ff));
      chg           = accept && have_last_ff && (new_rgb != disp_rgb);

      last_temp_in = last_temp_ff;
      have_last_in = have_last_ff;
      rising_in    = rising_ff;
      band_in      = band_ff;
      disp_in      = disp_ff;
      if (accept) begin
         last_temp_in = temp;
         have_last_in = 1'b1;
         rising_in    = rising_use;
         band_in      = moved_band;
         if (!have_last_ff || chg) begin
            disp_in = moved_band;
         end
      end

      cur_rgb             = band_color(int'(band_in));
      result.accepted     = accept;
      result.color_change = chg;
      result.band         = BAND_OUT_W'(band_in);
      result.red          = cur_rgb.red;
      result.green        = cur_rgb.green;
      result.blue         = cur_rgb.blue;
      result.rising       = rising_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_temp_ff <= '0;
         have_last_ff <= 1'b0;
         rising_ff    <= 1'b1;
         band_ff      <= '0;
         disp_ff      <= '0;
      end else if (step) begin
         last_temp_ff <= last_temp_in;
         have_last_ff <= have_last_in;
         rising_ff    <= rising_in;
         band_ff      <= band_in;
         disp_ff      <= disp_in;
      end
   end

endmodule
